[rtl/core/ebpd_pkg.sv]
// ----------------------------------------------------------------------------
// Escaped byte packet deframer package
// Register indexes, reset values and the result word type of the deframer.
// ----------------------------------------------------------------------------
package ebpd_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_CODE  = 3'd0;
    localparam logic [2:0] CFG_END_PREFIX  = 3'd1;
    localparam logic [2:0] CFG_ESCAPE_CODE = 3'd2;
    localparam logic [2:0] CFG_ESCAPE_MASK = 3'd3;
    localparam logic [2:0] CFG_MAX_LENGTH  = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [7:0]  RST_START_CODE  = 8'd122;
    localparam logic [7:0]  RST_END_PREFIX  = 8'd123;
    localparam logic [7:0]  RST_ESCAPE_CODE = 8'd125;
    localparam logic [7:0]  RST_ESCAPE_MASK = 8'd32;
    localparam logic [15:0] RST_MAX_LENGTH  = 16'd4096;

    // Number of little-endian length bytes at the head of a packet.
    localparam int unsigned HEADER_BYTES = 4;

    // One result word.
    typedef struct packed {
        logic        store_valid;
        logic [15:0] store_index;
        logic [7:0]  store_data;
        logic        packet_done;
        logic        packet_dropped;
        logic [15:0] packet_length;
    } t_result;

endpackage

[rtl/core/escaped_byte_packet_deframer_top.sv]
// ----------------------------------------------------------------------------
// Escaped byte packet deframer
// Strips start, end-prefix and escape codes from a framed byte stream, reads
// the little-endian length header and, for a packet within the length limit,
// issues one store write per payload byte.
//   Channel | Handshake                 | Payload
//   --------+---------------------------+------------------------------------
//   in      | i_in_valid / o_in_ready   | i_in_byte
//   out     | o_out_valid / i_out_ready | o_store_*, o_packet_*
//   cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// Each word is decoded in the cycle it is accepted; its result sits in the
// output register from the next cycle, so one word per clock is sustained
// unless a stalled output holds the input off. The output register frees
// in the cycle it is taken, so input and output may both move in the same
// cycle. Synchronous active-low reset clears the packet state and loads the
// default control codes. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module escaped_byte_packet_deframer_top
    import ebpd_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_store_valid,
    output logic [15:0] o_store_index,
    output logic [7:0]  o_store_data,
    output logic        o_packet_done,
    output logic        o_packet_dropped,
    output logic [15:0] o_packet_length,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Configuration registers.
    logic [7:0]  r_start_code;
    logic [7:0]  r_end_prefix;
    logic [7:0]  r_escape_code;
    logic [7:0]  r_escape_mask;
    logic [15:0] r_max_length;

    // Packet state.
    logic                   r_in_packet,   n_in_packet;
    logic                   r_escape_pend, n_escape_pend;
    logic                   r_end_pend,    n_end_pend;
    logic                   r_buffer_ok,   n_buffer_ok;
    logic [OFFSET_BITS-1:0] r_offset,      n_offset;
    logic [31:0]            r_length,      n_length;

    // Output register.
    logic    r_out_valid;
    t_result r_result, n_result;

    logic in_fire;
    logic cfg_fire;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid;

    // Decode of one byte: control codes first, then header, payload and end.
    always_comb begin
        logic [7:0]  data_byte;
        logic        finish;
        n_in_packet   = r_in_packet;
        n_escape_pend = r_escape_pend;
        n_end_pend    = r_end_pend;
        n_buffer_ok   = r_buffer_ok;
        n_offset      = r_offset;
        n_length      = r_length;
        n_result      = '0;
        data_byte     = i_in_byte;
        finish        = 1'b0;

        if (i_in_byte == r_start_code) begin
            n_offset    = '0;
            n_in_packet = 1'b1;
            n_end_pend  = 1'b0;
            n_buffer_ok = 1'b0;
        end else if (i_in_byte == r_end_prefix) begin
            n_end_pend = 1'b1;
        end else if (i_in_byte == r_escape_code) begin
            n_escape_pend = 1'b1;
        end else begin
            if (r_escape_pend) begin
                data_byte     = i_in_byte ^ r_escape_mask;
                n_escape_pend = 1'b0;
            end
            if (r_in_packet) begin
                finish = r_end_pend;
                if (32'(r_offset) < 32'(HEADER_BYTES)) begin
                    // Header byte: fill the length word little-endian.
                    case (r_offset[1:0])
                        2'd0:    n_length[7:0]   = data_byte;
                        2'd1:    n_length[15:8]  = data_byte;
                        2'd2:    n_length[23:16] = data_byte;
                        default: n_length[31:24] = data_byte;
                    endcase
                    n_offset = r_offset + 1'b1;
                    if (32'(n_offset) == 32'(HEADER_BYTES)) begin
                        n_buffer_ok = (n_length <= 32'(r_max_length));
                    end
                end else if (32'(r_offset) >= r_length) begin
                    // Byte past the announced length drops the packet.
                    n_result.packet_dropped = 1'b1;
                    finish                  = 1'b0;
                    n_in_packet             = 1'b0;
                    n_end_pend              = 1'b0;
                    n_offset                = '0;
                    n_buffer_ok             = 1'b0;
                end else if (r_buffer_ok) begin
                    n_result.store_valid = 1'b1;
                    n_result.store_index = 16'(r_offset);
                    n_result.store_data  = data_byte;
                    n_offset             = r_offset + 1'b1;
                end

                // The byte after an end prefix closes the packet.
                if (finish) begin
                    if ((32'(n_offset) == n_length) && n_buffer_ok) begin
                        n_result.packet_done   = 1'b1;
                        n_result.packet_length = n_length[15:0];
                    end else begin
                        n_result.packet_dropped = 1'b1;
                    end
                    n_in_packet = 1'b0;
                    n_end_pend  = 1'b0;
                    n_offset    = '0;
                    n_buffer_ok = 1'b0;
                end
            end
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code  <= RST_START_CODE;
            r_end_prefix  <= RST_END_PREFIX;
            r_escape_code <= RST_ESCAPE_CODE;
            r_escape_mask <= RST_ESCAPE_MASK;
            r_max_length  <= RST_MAX_LENGTH;
        end else if (cfg_fire) begin
            case (i_cfg_index)
                CFG_START_CODE:  r_start_code  <= i_cfg_data[7:0];
                CFG_END_PREFIX:  r_end_prefix  <= i_cfg_data[7:0];
                CFG_ESCAPE_CODE: r_escape_code <= i_cfg_data[7:0];
                CFG_ESCAPE_MASK: r_escape_mask <= i_cfg_data[7:0];
                CFG_MAX_LENGTH:  r_max_length  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Packet state advances on each accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet   <= 1'b0;
            r_escape_pend <= 1'b0;
            r_end_pend    <= 1'b0;
            r_buffer_ok   <= 1'b0;
            r_offset      <= '0;
            r_length      <= '0;
        end else if (in_fire) begin
            r_in_packet   <= n_in_packet;
            r_escape_pend <= n_escape_pend;
            r_end_pend    <= n_end_pend;
            r_buffer_ok   <= n_buffer_ok;
            r_offset      <= n_offset;
            r_length      <= n_length;
        end
    end

    // Output register: loaded on accept, emptied when taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_store_valid    = r_result.store_valid;
    assign o_store_index    = r_result.store_index;
    assign o_store_data     = r_result.store_data;
    assign o_packet_done    = r_result.packet_done;
    assign o_packet_dropped = r_result.packet_dropped;
    assign o_packet_length  = r_result.packet_length;

    // The buffer is only marked good inside a packet.
    a_ok_in_packet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buffer_ok |-> r_in_packet)
        else $error("buffer marked good outside a packet");

    // A good buffer means the whole header has been read.
    a_ok_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buffer_ok |-> (32'(r_offset) >= 32'(HEADER_BYTES)))
        else $error("buffer marked good before the header is complete");

    // Outside a packet the offset is held at zero.
    a_idle_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_packet |-> (r_offset == '0))
        else $error("offset not cleared outside a packet");

    // A packet is never reported as both accepted and dropped.
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_packet_done && o_packet_dropped))
        else $error("packet both accepted and dropped in one result word");

    // Store writes never land in the header.
    a_store_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_store_valid) |-> (o_store_index >= 16'(HEADER_BYTES)))
        else $error("store write inside the header");

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Testbench for the escaped byte packet deframer
// Streams framed bytes through the deframer under several code settings and
// idling patterns. A built-in predictor follows every accepted byte, and each
// result word is checked against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb_top;
    import ebpd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_byte = 8'd0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = CFG_START_CODE;
    logic [15:0] cfg_data = 16'd0;

    logic        o_in_ready;
    logic        o_out_valid;
    logic        o_store_valid;
    logic [15:0] o_store_index;
    logic [7:0]  o_store_data;
    logic        o_packet_done;
    logic        o_packet_dropped;
    logic [15:0] o_packet_length;
    logic        o_cfg_ready;

    // Bytes still to be sent and result words still to be seen.
    logic [7:0]  stream_q[$];
    t_result     deframed_q[$];

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    // Predictor copy of the control codes and length limit.
    logic [7:0]  code_start = RST_START_CODE;
    logic [7:0]  code_end = RST_END_PREFIX;
    logic [7:0]  code_esc = RST_ESCAPE_CODE;
    logic [7:0]  esc_mask = RST_ESCAPE_MASK;
    logic [15:0] max_len = RST_MAX_LENGTH;

    // Predictor copy of the framing state.
    logic        pkt_open = 1'b0;
    logic        esc_armed = 1'b0;
    logic        end_armed = 1'b0;
    logic        store_ok = 1'b0;
    logic [15:0] pkt_offset = 16'd0;
    logic [31:0] len_word = 32'd0;

    escaped_byte_packet_deframer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_byte        (in_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_store_valid    (o_store_valid),
        .o_store_index    (o_store_index),
        .o_store_data     (o_store_data),
        .o_packet_done    (o_packet_done),
        .o_packet_dropped (o_packet_dropped),
        .o_packet_length  (o_packet_length),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void close_packet();
        pkt_open   = 1'b0;
        end_armed  = 1'b0;
        store_ok   = 1'b0;
        pkt_offset = 16'd0;
    endfunction

    // Advances the predicted framing state by one raw byte and returns the
    // result word that byte should produce.
    function automatic t_result deframe_byte(input logic [7:0] raw);
        t_result     r;
        logic [7:0]  b;
        logic [31:0] len;
        r   = '0;
        b   = raw;
        len = len_word;
        // Control codes take priority in the order start, end prefix, escape.
        if (b == code_start) begin
            pkt_open   = 1'b1;
            end_armed  = 1'b0;
            store_ok   = 1'b0;
            pkt_offset = 16'd0;
            return r;
        end
        if (b == code_end) begin
            end_armed = 1'b1;
            return r;
        end
        if (b == code_esc) begin
            esc_armed = 1'b1;
            return r;
        end
        // A pending escape is used up even by a byte outside a packet.
        if (esc_armed) begin
            b = b ^ esc_mask;
            esc_armed = 1'b0;
        end
        if (!pkt_open) begin
            return r;
        end
        if (pkt_offset < HEADER_BYTES) begin
            len_word[8 * pkt_offset[1:0] +: 8] = b;
            pkt_offset = pkt_offset + 16'd1;
            if (pkt_offset == HEADER_BYTES) begin
                store_ok = (len_word <= {16'd0, max_len});
            end
            len = len_word;
        end else if ({16'd0, pkt_offset} >= len) begin
            r.packet_dropped = 1'b1;
            close_packet();
            return r;
        end else if (store_ok) begin
            r.store_valid = 1'b1;
            r.store_index = pkt_offset;
            r.store_data  = b;
            pkt_offset    = pkt_offset + 16'd1;
        end
        if (!end_armed) begin
            return r;
        end
        // The byte after an end prefix closes the packet.
        if ({16'd0, pkt_offset} == len && store_ok) begin
            r.packet_done   = 1'b1;
            r.packet_length = len[15:0];
        end else begin
            r.packet_dropped = 1'b1;
        end
        close_packet();
        return r;
    endfunction

    function automatic bit is_code(input logic [7:0] v);
        return (v == code_start) || (v == code_end) || (v == code_esc);
    endfunction

    // Queues one data byte, escaping it where it clashes with a code and now
    // and then without need. A byte that cannot be sent as data is bumped.
    task automatic queue_data(input logic [7:0] value);
        logic       esc_usable;
        logic [7:0] v;
        v = value;
        esc_usable = (code_esc != code_start) && (code_esc != code_end);
        while (is_code(v) && !(esc_usable && !is_code(v ^ esc_mask))) begin
            v = v + 8'd1;
        end
        if (is_code(v) || (esc_usable && !is_code(v ^ esc_mask) &&
                           $urandom_range(15) == 0)) begin
            stream_q.push_back(code_esc);
            stream_q.push_back(v ^ esc_mask);
        end else begin
            stream_q.push_back(v);
        end
    endtask

    // Queues a packet: start code, then n_data data bytes of which the first
    // four carry the length header. When closed, the end prefix goes before
    // the last data byte.
    task automatic queue_packet(input logic [31:0] hdr, input int unsigned n_data,
                                input bit closed);
        stream_q.push_back(code_start);
        for (int unsigned i = 0; i < n_data; i++) begin
            if (closed && i == n_data - 1) begin
                stream_q.push_back(code_end);
            end
            if (i < HEADER_BYTES) begin
                queue_data(hdr[8 * i +: 8]);
            end else begin
                queue_data(8'($urandom));
            end
        end
    endtask

    // Mostly well-formed packets with random content, the rest being length
    // errors, oversized headers, cut headers, restarts and raw noise.
    task automatic queue_random(input int unsigned count);
        int unsigned base;
        int unsigned sel;
        int unsigned plen;
        int unsigned k;
        logic [31:0] hdr;
        base = stream_q.size();
        while (stream_q.size() - base < count) begin
            sel  = $urandom_range(99);
            plen = ($urandom_range(49) == 0) ? $urandom_range(300) : $urandom_range(12);
            k    = $urandom_range(3, 1);
            if (sel < 55) begin
                queue_packet(4 + plen, 4 + plen, 1'b1);
            end else if (sel < 62) begin
                queue_packet(4 + plen, 4 + plen + k, 1'b1);
            end else if (sel < 69) begin
                queue_packet(4 + plen + k, 4 + plen, 1'b1);
            end else if (sel < 77) begin
                if ($urandom_range(1) == 0) begin
                    hdr = {16'd0, max_len} + 32'd1 + 32'($urandom_range(3));
                end else begin
                    hdr = $urandom | 32'h0001_0000;
                end
                queue_packet(hdr, 4 + plen, 1'b1);
            end else if (sel < 83) begin
                queue_packet($urandom, $urandom_range(3, 1), 1'b1);
            end else if (sel < 89) begin
                queue_packet(4 + plen + k, $urandom_range(4 + plen, 1), 1'b0);
            end else begin
                repeat ($urandom_range(8, 1)) stream_q.push_back(8'($urandom));
            end
        end
    endtask

    // Waits until every queued byte has been sent and every word has come back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (stream_q.size() != 0 || in_valid || deframed_q.size() != 0);
    endtask

    // Writes all five registers in index order and updates the predictor copy.
    task automatic write_codes(input logic [7:0] start_v, input logic [7:0] end_v,
                               input logic [7:0] esc_v, input logic [7:0] mask_v,
                               input logic [15:0] max_v);
        logic [2:0]  reg_ids [5];
        logic [15:0] vals [5];
        reg_ids = '{CFG_START_CODE, CFG_END_PREFIX, CFG_ESCAPE_CODE,
                    CFG_ESCAPE_MASK, CFG_MAX_LENGTH};
        vals    = '{{8'd0, start_v}, {8'd0, end_v}, {8'd0, esc_v}, {8'd0, mask_v}, max_v};
        @(posedge i_clk);
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= reg_ids[i];
            cfg_data  <= vals[i];
            do @(posedge i_clk);
            while (!o_cfg_ready);
            case (reg_ids[i])
                CFG_START_CODE: begin
                    code_start = vals[i][7:0];
                end
                CFG_END_PREFIX: begin
                    code_end = vals[i][7:0];
                end
                CFG_ESCAPE_CODE: begin
                    code_esc = vals[i][7:0];
                end
                CFG_ESCAPE_MASK: begin
                    esc_mask = vals[i][7:0];
                end
                default: begin
                    max_len = vals[i];
                end
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Driver: predicts each accepted byte and presents the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                deframed_q.push_back(deframe_byte(in_byte));
            end
            if (!in_valid || o_in_ready) begin
                if (stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_byte  <= stream_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result word and stalls at random.
    always @(posedge i_clk) begin
        t_result got;
        t_result exp;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                got = {o_store_valid, o_store_index, o_store_data,
                       o_packet_done, o_packet_dropped, o_packet_length};
                if (deframed_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("Unexpected result word: store %0b idx %0d data %h",
                                 got.store_valid, got.store_index, got.store_data);
                    end
                end else begin
                    exp = deframed_q.pop_front();
                    if (got !== exp) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("Mismatch expected: store %0b idx %0d data %h done %0b drop %0b len %0d",
                                     exp.store_valid, exp.store_index, exp.store_data,
                                     exp.packet_done, exp.packet_dropped, exp.packet_length);
                            $display("         actual:   store %0b idx %0d data %h done %0b drop %0b len %0d",
                                     got.store_valid, got.store_index, got.store_data,
                                     got.packet_done, got.packet_dropped, got.packet_length);
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset codes, no idling. Directed cases first: data and an escape
        // outside a packet, both byte extremes and a start right after an end prefix.
        stream_q.push_back(8'h00);
        stream_q.push_back(8'hFF);
        stream_q.push_back(code_esc);
        stream_q.push_back(8'h5A);
        stream_q.push_back(code_start);
        queue_data(8'd7);
        queue_data(8'd0);
        queue_data(8'd0);
        queue_data(8'd0);
        queue_data(8'h00);
        queue_data(8'hFF);
        stream_q.push_back(code_end);
        stream_q.push_back(code_start ^ esc_mask ^ esc_mask);
        // An escape followed by a start stays pending into the header.
        stream_q.push_back(code_esc);
        stream_q.push_back(code_start);
        stream_q.push_back(8'd4 ^ esc_mask);
        stream_q.push_back(8'd0);
        stream_q.push_back(8'd0);
        stream_q.push_back(code_end);
        stream_q.push_back(8'd0);
        // Length below the header size, then an end inside the header whose
        // partial length matches.
        queue_packet(32'd2, 5, 1'b0);
        queue_packet(32'd1, 1, 1'b1);
        queue_random(80);
        wait_drained();

        // Random distinct codes and a small length limit; sender idles.
        send_idle_pct = 51;
        c0 = 8'($urandom);
        do c1 = 8'($urandom); while (c1 == c0);
        do c2 = 8'($urandom); while (c2 == c0 || c2 == c1);
        write_codes(c0, c1, c2, 8'($urandom_range(255, 1)), 16'($urandom_range(40, 8)));
        queue_packet({16'd0, max_len}, 32'(max_len), 1'b1);
        queue_packet({16'd0, max_len} + 32'd1, 32'(max_len) + 32'd1, 1'b1);
        queue_random(80);
        wait_drained();
        queue_random(80);
        wait_drained();

        // Extreme codes: end prefix shadows escape, zero mask, widest limit.
        send_idle_pct  = 0;
        recv_stall_pct = 51;
        write_codes(8'hFF, 8'h01, 8'h01, 8'h00, 16'hFFFF);
        queue_random(160);
        wait_drained();

        // Start shadows end prefix, full mask, limit of the header size.
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        write_codes(8'h00, 8'h00, 8'hFF, 8'hFF, 16'd4);
        queue_random(50);
        wait_drained();

        // Back to the default codes, written explicitly.
        write_codes(RST_START_CODE, RST_END_PREFIX, RST_ESCAPE_CODE,
                    RST_ESCAPE_MASK, RST_MAX_LENGTH);
        queue_random(100);
        wait_drained();

        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/ebpd_pkg.sv
rtl/core/escaped_byte_packet_deframer_top.sv
verif/tb_top.sv
